@@ design/cds_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cds_pkg
// shared constants and small calendar helpers for the date shifter
// ---------------------------------------------------------------------------
package cds_pkg;

	localparam logic [1:0] UNIT_DAYS   = 2'd0;
	localparam logic [1:0] UNIT_WEEKS  = 2'd1;
	localparam logic [1:0] UNIT_MONTHS = 2'd2;
	localparam logic [1:0] UNIT_YEARS  = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_BADIN = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam int YEAR_LO = 1900;
	localparam int YEAR_HI = 9999;

	// day numbers of 1900-01-01 and 9999-12-31
	localparam int DN_LO = 693901;
	localparam int DN_HI = 3652364;

	// leap test for 14-bit years, mod 100 and mod 400 via reciprocal multiply
	function automatic logic is_leap(input logic [13:0] y);
		logic [13:0] q100;
		logic [13:0] r100;
		logic [27:0] prod;
		begin
			prod = 28'(y) * 28'd655;
			q100 = 14'(prod[27:16]);
			if (y - q100 * 14'd100 >= 14'd100) q100 = q100 + 14'd1;
			r100 = y - 14'(q100 * 14'd100);
			is_leap = (y[1:0] == 2'b00) && ((r100 != 14'd0) || (q100[1:0] == 2'b00));
		end
	endfunction

	function automatic logic [4:0] month_days(input logic [13:0] y, input logic [3:0] m);
		begin
			case (m)
				4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_days = 5'd31;
				4'd4, 4'd6, 4'd9, 4'd11: month_days = 5'd30;
				4'd2: month_days = is_leap(y) ? 5'd29 : 5'd28;
				default: month_days = 5'd0;
			endcase
		end
	endfunction

	// days before the month in a march-based year
	function automatic logic [8:0] march_offset(input logic [3:0] mp);
		begin
			case (mp)
				4'd0:  march_offset = 9'd0;
				4'd1:  march_offset = 9'd31;
				4'd2:  march_offset = 9'd61;
				4'd3:  march_offset = 9'd92;
				4'd4:  march_offset = 9'd122;
				4'd5:  march_offset = 9'd153;
				4'd6:  march_offset = 9'd184;
				4'd7:  march_offset = 9'd214;
				4'd8:  march_offset = 9'd245;
				4'd9:  march_offset = 9'd275;
				4'd10: march_offset = 9'd306;
				4'd11: march_offset = 9'd337;
				default: march_offset = 9'd0;
			endcase
		end
	endfunction

	// year of era divided by 100, exact for 0..399
	function automatic logic [2:0] yoe_div100(input logic [8:0] yoe);
		logic [14:0] prod;
		begin
			prod = 15'(yoe) * 15'd41;
			yoe_div100 = prod[14:12];
		end
	endfunction

endpackage

@@ design/civil_date_shift.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// civil_date_shift
// shifts a gregorian date by days, weeks, months or years
// ---------------------------------------------------------------------------
// channel  signals                                         dir
// in       in_valid in_ready year_in month_in day_in       in
//          amount unit
// out      out_valid out_ready status year_out month_out   out
//          day_out
// one transaction per cycle unless out_ready stalls it, six register stages
// stage 1 checks the date, stage 2 forms the day number, later stages
// split the target back into era, year, month and day
// reset clears only the valid bits
// a stall holds each full stage whose successor cannot move, nothing is lost
// ---------------------------------------------------------------------------
module civil_date_shift import cds_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [13:0]        year_in,
	input  logic [3:0]         month_in,
	input  logic [4:0]         day_in,
	input  logic signed [31:0] amount,
	input  logic [1:0]         unit,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [13:0]        year_out,
	output logic [3:0]         month_out,
	output logic [4:0]         day_out
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	assign en6 = !v_s6 || out_ready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// stage 1: validity, day of era pieces, month target
	logic        bad0;
	logic [13:0] yy0;
	logic [3:0]  mp0;
	logic [8:0]  doy0;
	logic [4:0]  lim0;
	logic [17:0] mt0;
	logic signed [34:0] delta0;

	always_comb begin
		lim0 = month_days(year_in, month_in);
		bad0 = (year_in < 14'(YEAR_LO)) || (year_in > 14'(YEAR_HI)) || (month_in < 4'd1)
			|| (month_in > 4'd12) || (day_in == 5'd0) || (day_in > lim0);
		yy0  = year_in - ((month_in <= 4'd2) ? 14'd1 : 14'd0);
		mp0  = (month_in > 4'd2) ? month_in - 4'd3 : month_in + 4'd9;
		doy0 = march_offset(mp0) + 9'(day_in) - 9'd1;
		mt0  = 18'(year_in) * 18'd12 + 18'(month_in) - 18'd1;
		delta0 = (unit == UNIT_WEEKS) ? 35'(amount) * 35'sd7 : 35'(amount);
	end

	logic        bad_s1;
	logic [1:0]  unit_s1;
	logic [13:0] yy_s1, y_s1;
	logic [8:0]  doy_s1;
	logic [4:0]  d_s1;
	logic [17:0] mt_s1;
	logic signed [34:0] delta_s1;
	logic signed [31:0] amt_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			bad_s1 <= bad0; unit_s1 <= unit; yy_s1 <= yy0; y_s1 <= year_in;
			doy_s1 <= doy0; d_s1 <= day_in; mt_s1 <= mt0; delta_s1 <= delta0;
			amt_s1 <= amount;
		end
	end

	// stage 2: day number and shifted targets
	logic [4:0]  era1;
	logic [8:0]  yoe1;
	logic [21:0] dn1;
	logic signed [35:0] tdn1, tmon1, tyr1;
	logic [31:0] q400;

	always_comb begin
		q400 = 32'(yy_s1) * 32'd10486;
		era1 = 5'(q400 >> 22);
		if (yy_s1 - 14'(era1 * 14'd400) >= 14'd400) era1 = era1 + 5'd1;
		yoe1 = 9'(yy_s1 - 14'(era1 * 14'd400));
		dn1  = 22'(era1) * 22'd146097 + 22'(yoe1) * 22'd365 + 22'(yoe1 >> 2)
			- 22'(yoe_div100(yoe1)) + 22'(doy_s1);
		tdn1  = 36'(signed'({1'b0, dn1})) + 36'(delta_s1);
		tmon1 = 36'(signed'({1'b0, mt_s1})) + 36'(amt_s1);
		tyr1  = 36'(signed'({1'b0, y_s1})) + 36'(amt_s1);
	end

	logic [1:0]  st_s2;
	logic [1:0]  unit_s2;
	logic [21:0] tdn_s2;
	logic [17:0] tmon_s2;
	logic [13:0] tyr_s2;
	logic [4:0]  d_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			unit_s2 <= unit_s1; d_s2 <= d_s1;
			tdn_s2 <= 22'(tdn1); tmon_s2 <= 18'(tmon1); tyr_s2 <= 14'(tyr1);
			if (bad_s1) st_s2 <= ST_BADIN;
			else if (unit_s1 == UNIT_DAYS || unit_s1 == UNIT_WEEKS)
				st_s2 <= (tdn1 < 36'(DN_LO) || tdn1 > 36'(DN_HI)) ? ST_RANGE : ST_OK;
			else if (unit_s1 == UNIT_MONTHS)
				st_s2 <= (tmon1 < 36'sd22800 || tmon1 > 36'sd119999) ? ST_RANGE : ST_OK;
			else
				st_s2 <= (tyr1 < 36'sd1900 || tyr1 > 36'sd9999) ? ST_RANGE : ST_OK;
		end
	end

	// stage 3: era and day of era, year and month of month target
	logic [4:0]  era2;
	logic [17:0] doe2;
	logic [43:0] qe;
	logic [13:0] my2;
	logic [3:0]  mm2;
	logic [35:0] q12;

	always_comb begin
		qe   = 44'(tdn_s2) * 44'd117592;
		era2 = 5'(qe >> 34);
		if (tdn_s2 - 22'(era2 * 22'd146097) >= 22'd146097) era2 = era2 + 5'd1;
		doe2 = 18'(tdn_s2 - 22'(era2) * 22'd146097);
		q12  = 36'(tmon_s2) * 36'd21845;
		my2  = 14'(q12 >> 18);
		if (tmon_s2 - 18'(my2) * 18'd12 >= 18'd12) my2 = my2 + 14'd1;
		mm2  = 4'(tmon_s2 - 18'(my2) * 18'd12) + 4'd1;
	end

	logic [1:0]  st_s3, unit_s3;
	logic [4:0]  era_s3, d_s3;
	logic [17:0] doe_s3;
	logic [13:0] my_s3;
	logic [3:0]  mm_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			st_s3 <= st_s2; unit_s3 <= unit_s2; era_s3 <= era2; doe_s3 <= doe2;
			d_s3 <= d_s2;
			if (unit_s2 == UNIT_MONTHS) begin
				my_s3 <= my2; mm_s3 <= mm2;
			end else begin
				my_s3 <= tyr_s2; mm_s3 <= 4'd0;
			end
		end
	end

	// stage 4: year of era
	logic [17:0] t3;
	logic [8:0]  yoe3;
	logic [35:0] q365;
	logic [35:0] q1460;
	logic [2:0]  c36524;

	always_comb begin
		q1460  = 36'(doe_s3) * 36'd183860;
		c36524 = 3'(doe_s3 >= 18'd36524) + 3'(doe_s3 >= 18'd73048)
			+ 3'(doe_s3 >= 18'd109572) + 3'(doe_s3 >= 18'd146096);
		t3 = doe_s3 - 18'(q1460 >> 28) + 18'(c36524) - 18'(doe_s3 == 18'd146096);
		q365 = 36'(t3) * 36'd183860;
		yoe3 = 9'(q365 >> 26);
		if (t3 - 18'(yoe3) * 18'd365 >= 18'd365) yoe3 = yoe3 + 9'd1;
	end

	logic [1:0]  st_s4, unit_s4;
	logic [4:0]  era_s4, d_s4;
	logic [17:0] doe_s4;
	logic [8:0]  yoe_s4;
	logic [13:0] my_s4;
	logic [3:0]  mm_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			st_s4 <= st_s3; unit_s4 <= unit_s3; era_s4 <= era_s3; d_s4 <= d_s3;
			doe_s4 <= doe_s3; yoe_s4 <= yoe3; my_s4 <= my_s3; mm_s4 <= mm_s3;
		end
	end

	// stage 5: day of year and month
	logic [8:0] doy4;
	logic [3:0] mp4;
	logic [13:0] y4;
	logic [3:0]  m4;
	logic [4:0]  dd4;
	logic [11:0] x4;
	logic [24:0] qmp4;

	always_comb begin
		doy4 = 9'(doe_s4 - (18'(yoe_s4) * 18'd365 + 18'(yoe_s4 >> 2)
			- 18'(yoe_div100(yoe_s4))));
		x4   = 12'(doy4) * 12'd5 + 12'd2;
		qmp4 = 25'(x4) * 25'd6854;
		mp4  = 4'(qmp4 >> 20);
		m4   = (mp4 < 4'd10) ? mp4 + 4'd3 : mp4 - 4'd9;
		dd4  = 5'(doy4 - march_offset(mp4) + 9'd1);
		y4   = 14'(yoe_s4) + 14'(era_s4) * 14'd400 + ((m4 <= 4'd2) ? 14'd1 : 14'd0);
	end

	logic [1:0]  st_s5, unit_s5;
	logic [13:0] y_s5, my_s5;
	logic [3:0]  m_s5, mm_s5;
	logic [4:0]  dd_s5, d_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			st_s5 <= st_s4; unit_s5 <= unit_s4; y_s5 <= y4; m_s5 <= m4; dd_s5 <= dd4;
			my_s5 <= my_s4; mm_s5 <= mm_s4; d_s5 <= d_s4;
		end
	end

	// stage 6: clamp and select
	logic [1:0]  st_s6;
	logic [13:0] y_s6;
	logic [3:0]  m_s6;
	logic [4:0]  d_s6;

	// year unit keeps the input month, carried alongside the pipeline
	logic [3:0] m_in_s1, m_in_s2, m_in_s3, m_in_s4, m_in_s5;
	always_ff @(posedge clk) begin
		if (en1) m_in_s1 <= month_in;
		if (en2) m_in_s2 <= m_in_s1;
		if (en3) m_in_s3 <= m_in_s2;
		if (en4) m_in_s4 <= m_in_s3;
		if (en5) m_in_s5 <= m_in_s4;
	end

	logic [3:0] sm5;
	logic [4:0] sl5;
	always_comb begin
		sm5 = (unit_s5 == UNIT_YEARS) ? m_in_s5 : mm_s5;
		sl5 = month_days(my_s5, sm5);
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			st_s6 <= st_s5;
			if (st_s5 != ST_OK) begin
				y_s6 <= 14'd0; m_s6 <= 4'd0; d_s6 <= 5'd0;
			end else if (unit_s5 == UNIT_DAYS || unit_s5 == UNIT_WEEKS) begin
				y_s6 <= y_s5; m_s6 <= m_s5; d_s6 <= dd_s5;
			end else begin
				y_s6 <= my_s5; m_s6 <= sm5;
				d_s6 <= (d_s5 > sl5) ? sl5 : d_s5;
			end
		end
	end

	assign out_valid = v_s6;
	assign status    = st_s6;
	assign year_out  = y_s6;
	assign month_out = m_s6;
	assign day_out   = d_s6;

endmodule

@@ design/cds_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cds_checker
// port level checks for the date shifter
// ---------------------------------------------------------------------------
module cds_checker import cds_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [13:0] year_out,
	input logic [3:0]  month_out,
	input logic [4:0]  day_out
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(year_out))
		else $error("stalled transaction changed");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> year_out == 14'd0 && month_out == 4'd0
		&& day_out == 5'd0)
		else $error("failed transaction carries a date");

	a_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> month_out >= 4'd1 && month_out <= 4'd12
		&& day_out >= 5'd1 && year_out >= 14'd1900 && year_out <= 14'd9999)
		else $error("bad date on good transaction");

	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("unknown status");

	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind civil_date_shift cds_checker u_cds_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready), .out_valid(out_valid),
	.out_ready(out_ready), .status(status), .year_out(year_out),
	.month_out(month_out), .day_out(day_out)
);

@@ tb/sv/civil_date_shift_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// civil_date_shift_tb
// self-checking bench for the date shifter: a directed table of corner dates
// and units, then random dates and amounts, with random idle cycles on both
// sides and one long output hold-off; every result is checked against an
// in-bench calendar predictor
// ---------------------------------------------------------------------------
module civil_date_shift_tb;
	import cds_pkg::*;

	localparam int N_RANDOM  = 1200;
	localparam int WDOG_MAX  = 20000;
	localparam int LATENCY   = 6;
	localparam int HOLD_LEN  = 300;

	typedef struct packed {
		logic [13:0]        y;
		logic [3:0]         m;
		logic [4:0]         d;
		logic signed [31:0] amt;
		logic [1:0]         u;
	} shift_req_t;

	typedef struct packed {
		logic [1:0]  st;
		logic [13:0] y;
		logic [3:0]  m;
		logic [4:0]  d;
	} shift_res_t;

	typedef struct {
		shift_req_t req;
		logic       fixed;
		shift_res_t res;
	} dir_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [13:0]        year_in;
	logic [3:0]         month_in;
	logic [4:0]         day_in;
	logic signed [31:0] amount;
	logic [1:0]         unit;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         status;
	logic [13:0]        year_out;
	logic [3:0]         month_out;
	logic [4:0]         day_out;

	shift_res_t expected_dates[$];
	int         n_errors = 0;
	int         n_bad_rows = 0;
	int         n_sent = 0;
	int         n_checked = 0;
	int         n_ok = 0;
	int         n_badin = 0;
	int         n_range = 0;
	int         idle_cycles = 0;
	bit         stim_done;
	bit         hold_done;
	bit         quiet_in;
	bit         quiet_out;
	dir_row_t   dir_rows[$];

	civil_date_shift i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.year_in   (year_in),
		.month_in  (month_in),
		.day_in    (day_in),
		.amount    (amount),
		.unit      (unit),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.year_out  (year_out),
		.month_out (month_out),
		.day_out   (day_out)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic bit year_has_feb29(longint y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic longint month_len_days(longint y, longint m);
		longint lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		if (m < 1 || m > 12)
			return 0;
		if (m == 2 && year_has_feb29(y))
			return 29;
		return lens[m - 1];
	endfunction

	function automatic longint date_to_daynum(longint y, longint m, longint d);
		longint yy;
		longint era;
		longint yoe;
		longint mp;
		longint doy;
		yy  = y - (m <= 2 ? 1 : 0);
		era = yy / 400;
		yoe = yy - era * 400;
		mp  = m + (m > 2 ? -3 : 9);
		doy = (153 * mp + 2) / 5 + d - 1;
		return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy;
	endfunction

	function automatic shift_res_t shifted_date(shift_req_t r);
		shift_res_t o;
		longint y;
		longint m;
		longint d;
		longint amt;
		longint tgt;
		longint era;
		longint doe;
		longint yoe;
		longint doy;
		longint mp;
		y   = r.y;
		m   = r.m;
		d   = r.d;
		amt = r.amt;
		o   = '0;
		o.st = ST_OK;
		if (y < YEAR_LO || y > YEAR_HI || m < 1 || m > 12 || d < 1 ||
				d > month_len_days(y, m)) begin
			o.st = ST_BADIN;
		end else if (r.u == UNIT_DAYS || r.u == UNIT_WEEKS) begin
			tgt = date_to_daynum(y, m, d) + ((r.u == UNIT_WEEKS) ? amt * 7 : amt);
			if (tgt < date_to_daynum(YEAR_LO, 1, 1) || tgt > date_to_daynum(YEAR_HI, 12, 31)) begin
				o.st = ST_RANGE;
			end else begin
				era = tgt / 146097;
				doe = tgt - era * 146097;
				yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
				doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
				mp  = (5 * doy + 2) / 153;
				d   = doy - (153 * mp + 2) / 5 + 1;
				m   = mp + (mp < 10 ? 3 : -9);
				y   = yoe + era * 400 + (m <= 2 ? 1 : 0);
			end
		end else begin
			if (r.u == UNIT_MONTHS) begin
				tgt = y * 12 + (m - 1) + amt;
				if (tgt < longint'(YEAR_LO) * 12 || tgt > longint'(YEAR_HI) * 12 + 11) begin
					o.st = ST_RANGE;
				end else begin
					y = tgt / 12;
					m = tgt % 12 + 1;
				end
			end else begin
				tgt = y + amt;
				if (tgt < YEAR_LO || tgt > YEAR_HI)
					o.st = ST_RANGE;
				else
					y = tgt;
			end
			if (o.st == ST_OK && d > month_len_days(y, m))
				d = month_len_days(y, m);
		end
		if (o.st == ST_OK) begin
			o.y = y[13:0];
			o.m = m[3:0];
			o.d = d[4:0];
		end
		return o;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %0s at result %0d: got %0d expected %0d", what, n_checked, got, want);
		n_errors++;
	endtask

	function automatic shift_req_t rand_request();
		shift_req_t r;
		int sel;
		sel = int'($urandom_range(99));
		r.u = 2'($urandom_range(3));
		if (sel < 85) begin
			r.y = 14'(($urandom_range(1, 100) <= 30) ? $urandom_range(1900, 1910) :
				(($urandom_range(1, 100) <= 30) ? $urandom_range(9990, 9999) :
				$urandom_range(1900, 9999)));
			r.m = 4'($urandom_range(1, 12));
			r.d = 5'($urandom_range(1, 32'(month_len_days(r.y, r.m))));
			if ($urandom_range(9) == 0)
				r.d = 5'($urandom_range(28, 31));
		end else begin
			r.y = 14'($urandom());
			r.m = 4'($urandom());
			r.d = 5'($urandom());
		end
		case ($urandom_range(5))
			0: r.amt = $urandom();
			1: r.amt = $signed($urandom_range(0, 4000)) - 2000;
			2: r.amt = $signed($urandom_range(0, 200000)) - 100000;
			3: r.amt = $signed($urandom_range(0, 8000000)) - 4000000;
			4: r.amt = $signed($urandom_range(0, 240)) - 120;
			default: r.amt = $urandom_range(1) ? 32'sh7fffffff - $urandom_range(3)
				: 32'sh80000000 + $urandom_range(3);
		endcase
		return r;
	endfunction

	task automatic send_date(shift_req_t r);
		while (!quiet_in && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		year_in  <= r.y;
		month_in <= r.m;
		day_in   <= r.d;
		amount   <= r.amt;
		unit     <= r.u;
		expected_dates.push_back(shifted_date(r));
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		n_sent++;
		@(negedge clk);
	endtask

	function automatic dir_row_t row(int y, int m, int d, int amt, logic [1:0] u,
			logic fixed = 1'b0, logic [1:0] st = ST_OK, int ey = 0, int em = 0, int ed = 0);
		dir_row_t t;
		t.req   = '{y[13:0], m[3:0], d[4:0], amt, u};
		t.fixed = fixed;
		t.res   = '{st, ey[13:0], em[3:0], ed[4:0]};
		return t;
	endfunction

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		out_ready = 1'b0;
		year_in   = '0;
		month_in  = '0;
		day_in    = '0;
		amount    = '0;
		unit      = UNIT_DAYS;
		quiet_in  = 1'b0;
		stim_done = 1'b0;
		dir_rows = '{
			row(1900, 1, 1, 0, UNIT_DAYS, 1, ST_OK, 1900, 1, 1),
			row(9999, 12, 31, 0, UNIT_DAYS, 1, ST_OK, 9999, 12, 31),
			row(1900, 1, 1, -1, UNIT_DAYS, 1, ST_RANGE),
			row(9999, 12, 31, 1, UNIT_DAYS, 1, ST_RANGE),
			row(1899, 12, 31, 0, UNIT_DAYS, 1, ST_BADIN),
			row(10000, 1, 1, 0, UNIT_DAYS, 1, ST_BADIN),
			row(16383, 15, 31, 0, UNIT_YEARS, 1, ST_BADIN),
			row(2000, 0, 1, 0, UNIT_MONTHS, 1, ST_BADIN),
			row(2000, 13, 1, 0, UNIT_DAYS, 1, ST_BADIN),
			row(2000, 1, 0, 0, UNIT_DAYS, 1, ST_BADIN),
			row(1900, 2, 29, 0, UNIT_DAYS, 1, ST_BADIN),
			row(2100, 2, 29, 0, UNIT_DAYS, 1, ST_BADIN),
			row(2000, 2, 29, 0, UNIT_DAYS, 1, ST_OK, 2000, 2, 29),
			row(2001, 4, 31, 0, UNIT_DAYS, 1, ST_BADIN),
			row(2000, 2, 29, 1, UNIT_YEARS, 1, ST_OK, 2001, 2, 28),
			row(2000, 1, 31, 1, UNIT_MONTHS, 1, ST_OK, 2000, 2, 29),
			row(2000, 3, 31, 1, UNIT_MONTHS, 1, ST_OK, 2000, 4, 30),
			row(2000, 1, 1, 7, UNIT_WEEKS),
			row(2000, 3, 1, -1, UNIT_DAYS),
			row(1900, 1, 31, -1, UNIT_MONTHS, 1, ST_RANGE),
			row(9999, 12, 1, 1, UNIT_MONTHS, 1, ST_RANGE),
			row(2000, 6, 15, 32'h7fffffff, UNIT_WEEKS, 1, ST_RANGE),
			row(2000, 6, 15, 32'h80000000, UNIT_YEARS, 1, ST_RANGE),
			row(1900, 1, 1, 2958463, UNIT_DAYS),
			row(1900, 1, 1, 96119, UNIT_MONTHS)
		};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (dir_rows[i]) begin
			send_date(dir_rows[i].req);
			if (dir_rows[i].fixed && shifted_date(dir_rows[i].req) != dir_rows[i].res) begin
				$display("table row %0d disagrees with predictor", i);
				n_bad_rows++;
			end
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			quiet_in = (i >= 400 && i < 600);
			send_date(rand_request());
		end
		in_valid  <= 1'b0;
		stim_done = 1'b1;
	end

	// output side: random stalls, one long hold-off, a quiet stretch
	initial begin
		hold_done = 1'b0;
		quiet_out = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			quiet_out = (n_sent >= 400 && n_sent < 600);
			if (!hold_done && n_sent >= 100) begin
				out_ready <= 1'b0;
				repeat (HOLD_LEN) @(negedge clk);
				hold_done = 1'b1;
			end
			out_ready <= quiet_out || ($urandom_range(99) >= 6);
		end
	end

	always @(posedge clk) begin
		shift_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_dates.size() == 0) begin
				$display("unexpected transaction: status %0d", status);
				n_errors++;
			end else begin
				want = expected_dates.pop_front();
				if (status !== want.st)
					report_mismatch("status", status, want.st);
				if (year_out !== want.y)
					report_mismatch("year", year_out, want.y);
				if (month_out !== want.m)
					report_mismatch("month", month_out, want.m);
				if (day_out !== want.d)
					report_mismatch("day", day_out, want.d);
				case (want.st)
					ST_OK: n_ok++;
					ST_BADIN: n_badin++;
					default: n_range++;
				endcase
			end
			n_checked++;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (idle_cycles > WDOG_MAX) begin
				$display("watchdog: no transaction for %0d cycles", WDOG_MAX);
				$display("civil_date_shift_tb failed");
				$finish;
			end
			if (stim_done && expected_dates.size() == 0) begin
				repeat (LATENCY * 4) @(posedge clk);
				$display("covered %0d dates: %0d shifted, %0d bad start, %0d out of span",
					n_checked, n_ok, n_badin, n_range);
				if (n_errors == 0 && n_bad_rows == 0 && expected_dates.size() == 0) begin
					$display("civil_date_shift_tb passed");
				end else begin
					$display("civil_date_shift_tb failed");
				end
				$finish;
			end
		end
	end

endmodule

@@ sim.f @@
design/cds_pkg.sv
design/civil_date_shift.sv
design/cds_checker.sv
tb/sv/civil_date_shift_tb.sv
